[design/mi3_pkg.sv]
// shared types and constants for the 3x3 adjugate matrix inverse
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

  // default word format, signed Q16.16
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // tolerance register width
  localparam int TOL_WIDTH = 31;

  // matrix geometry
  localparam int NUM_ENTRIES = 9;
  localparam logic [3:0] LAST_ENTRY = 4'd8;
  localparam logic [4:0] LAST_PROD  = 5'd20;
  localparam logic [4:0] FIRST_DET_PROD = 5'd18;

  // cofactor k = e[ix0]*e[ix1] - e[ix2]*e[ix3]
  localparam logic [3:0] COF_IX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OPA,
    ST_OPB,
    ST_MUL,
    ST_TERM,
    ST_DET,
    ST_DIV_GO,
    ST_DIV,
    ST_QUOT,
    ST_WAIT
  } state_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

`default_nettype wire

[design/mi3_mac.sv]
// shift-add multiply-accumulate unit, one multiplier bit per cycle
// depends on mi3_pkg for the control struct
`timescale 1ns / 1ps
`default_nettype none

module mi3_mac
  import mi3_pkg::*;
#(
  parameter int MW = ENTRY_WIDTH_DEF,
  parameter int AW = 3 * ENTRY_WIDTH_DEF + 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mac_ctl_t      ctl,
  input  wire logic [MW-1:0] mplier,
  input  wire logic [AW-1:0] mcand,
  output logic      [AW-1:0] acc,
  output logic               done
);

  localparam int CNTW = $clog2(MW + 1);

  logic [AW-1:0]   mc;
  logic [MW-1:0]   mp;
  logic [CNTW-1:0] cnt;
  logic            busy;

  // control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(MW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: add shifted multiplicand on each set multiplier bit
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mc <= mcand;
      mp <= mplier;
      if (ctl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

`default_nettype wire

[design/mi3_div.sv]
// restoring divider for unsigned magnitudes, one quotient bit per cycle
// depends on mi3_pkg for defaults
`timescale 1ns / 1ps
`default_nettype none

module mi3_div
  import mi3_pkg::*;
#(
  parameter int NW = 4 * ENTRY_WIDTH_DEF,
  parameter int DW = 3 * ENTRY_WIDTH_DEF + 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo,
  output logic               done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic            fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[NW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: numerator bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DW-1:0];
      end
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[design/matrix_inverse_3x3.sv]
// 3x3 matrix inverse by adjugate, signed fixed point, saturated results
// after the ninth entry the shift-add multiplier forms 21 products, then the
// determinant word is put out, then the bit-serial divider forms each inverse
// word in turn; entries are taken one per cycle while in_ready is high, one
// matrix at a time
// synchronous active-high reset clears the sequencer, counters and tolerance
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ENTRY_WIDTH-1:0] entry_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [ENTRY_WIDTH-1:0] result_value,
  output logic      [3:0]             result_index,
  output logic                        singular,
  output logic                        last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [TOL_WIDTH-1:0]   cfg_data
);

  localparam int W   = ENTRY_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CW  = 2 * W + 1;
  localparam int AW  = 3 * W + 2;
  localparam int NQ  = 2 * W + 2 * F;
  localparam int SW  = (AW > NQ) ? AW : NQ;
  localparam int XW  = (AW > TOL_WIDTH + 2 * F) ? AW : TOL_WIDTH + 2 * F;

  state_t state, state_next;

  logic [W-1:0]         store [NUM_ENTRIES];
  logic [CW-1:0]        cof [NUM_ENTRIES];
  logic [3:0]           load_count;
  logic [4:0]           prod;
  logic [3:0]           kdiv;
  logic [W-1:0]         op_a;
  logic                 det_neg;
  logic [AW-1:0]        det_mag;
  logic [TOL_WIDTH-1:0] tol;

  logic                 in_take;
  mac_ctl_t             mac_ctl;
  logic                 div_start;
  logic                 load_det;
  logic                 load_quot;

  logic                 is_det;
  logic [3:0]           k_idx;
  logic                 j_sel;
  logic [1:0]           di;
  logic [3:0]           st_addr;
  logic [3:0]           cof_addr;
  logic [W-1:0]         st_rd;
  logic [CW-1:0]        cof_rd;
  logic [W-1:0]         mplier;
  logic [AW-1:0]        mc_x;
  logic [AW-1:0]        mcand;
  logic [AW-1:0]        acc;
  logic                 mac_done;
  logic [AW-1:0]        acc_abs;
  logic [CW-1:0]        cof_abs;
  logic [NQ-1:0]        div_num;
  logic [NQ-1:0]        div_q;
  logic                 div_done;
  logic                 sing;
  logic [SW-1:0]        sat_in;
  logic                 sat_neg;
  logic [SW-1:0]        sat_lim;
  logic [SW-1:0]        sat_m;
  logic [W-1:0]         sat_val;

  // operand addressing from the product counter
  always_comb begin
    is_det   = prod >= FIRST_DET_PROD;
    k_idx    = is_det ? 4'd0 : prod[4:1];
    j_sel    = prod[0];
    di       = 2'(prod - FIRST_DET_PROD);
    if (state == ST_OPA) begin
      st_addr = is_det ? {2'b00, di} : COF_IX[k_idx][{j_sel, 1'b0}];
    end else begin
      st_addr = COF_IX[k_idx][{j_sel, 1'b1}];
    end
    if (state == ST_OPB) begin
      cof_addr = 4'({2'b00, di} * 4'd3);
    end else begin
      cof_addr = kdiv;
    end
    st_rd  = store[st_addr];
    cof_rd = cof[cof_addr];
  end

  // multiplier magnitude and signed multiplicand
  always_comb begin
    mplier = op_a[W-1] ? W'(-op_a) : op_a;
    if (is_det) begin
      mc_x = {{(AW-CW){cof_rd[CW-1]}}, cof_rd};
    end else begin
      mc_x = {{(AW-W){st_rd[W-1]}}, st_rd};
    end
    mcand = (op_a[W-1] ^ (!is_det && j_sel)) ? AW'(-mc_x) : mc_x;
  end

  mi3_mac #(
    .MW (W),
    .AW (AW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .mplier (mplier),
    .mcand  (mcand),
    .acc    (acc),
    .done   (mac_done)
  );

  // divider operands
  always_comb begin
    acc_abs = acc[AW-1] ? AW'(-acc) : acc;
    cof_abs = cof_rd[CW-1] ? CW'(-cof_rd) : cof_rd;
    div_num = NQ'(cof_abs[2*W-1:0]) << (2 * F);
  end

  mi3_div #(
    .NW (NQ),
    .DW (AW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_mag),
    .quo   (div_q),
    .done  (div_done)
  );

  // singular test and shared saturation
  always_comb begin
    sing = XW'(det_mag) <= (XW'(tol) << (2 * F));
    if (state == ST_DET) begin
      sat_in  = SW'(det_mag >> (2 * F));
      sat_neg = det_neg;
    end else begin
      sat_in  = SW'(div_q);
      sat_neg = cof_rd[CW-1] ^ det_neg;
    end
    sat_lim = sat_neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
    sat_m   = (sat_in > sat_lim) ? sat_lim : sat_in;
    sat_val = sat_neg ? W'(-sat_m[W-1:0]) : sat_m[W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && load_count == LAST_ENTRY) begin
          state_next = ST_OPA;
        end
      end
      ST_OPA:    state_next = ST_OPB;
      ST_OPB:    state_next = ST_MUL;
      ST_MUL: begin
        if (mac_done) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM:   state_next = (prod == LAST_PROD) ? ST_DET : ST_OPA;
      ST_DET:    state_next = ST_WAIT;
      ST_DIV_GO: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (out_ready) begin
          state_next = last ? ST_LOAD : ST_DIV_GO;
        end
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_take       = 1'b0;
    mac_ctl.start = 1'b0;
    mac_ctl.clear = is_det ? (di == 2'd0) : !j_sel;
    div_start     = 1'b0;
    load_det      = 1'b0;
    load_quot     = 1'b0;
    unique case (state)
      ST_LOAD:   in_take       = 1'b1;
      ST_OPB:    mac_ctl.start = 1'b1;
      ST_DET:    load_det      = 1'b1;
      ST_DIV_GO: div_start     = 1'b1;
      ST_QUOT:   load_quot     = 1'b1;
      default:   ;
    endcase
  end

  assign in_ready  = in_take;
  assign out_valid = (state == ST_WAIT);
  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      prod       <= '0;
      kdiv       <= '0;
      tol        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        tol <= cfg_data;
      end
      if (in_take && in_valid) begin
        load_count <= (load_count == LAST_ENTRY) ? 4'd0 : load_count + 4'd1;
        prod       <= '0;
      end
      if (state == ST_TERM) begin
        prod <= prod + 5'd1;
      end
      if (load_det) begin
        kdiv <= '0;
      end else if (state == ST_WAIT && out_ready && !last) begin
        kdiv <= (result_index == 4'd0) ? 4'd0 : kdiv + 4'd1;
      end
    end
  end

  // matrix store, cofactors, determinant and output word
  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      store[load_count] <= entry_value;
    end
    if (state == ST_OPA) begin
      op_a <= st_rd;
    end
    if (state == ST_TERM) begin
      if (!is_det && j_sel) begin
        cof[k_idx] <= acc[CW-1:0];
      end
      if (prod == LAST_PROD) begin
        det_neg <= acc[AW-1];
        det_mag <= acc_abs;
      end
    end
    if (load_det) begin
      result_value <= sat_val;
      result_index <= 4'd0;
      singular     <= sing;
      last         <= sing;
    end else if (load_quot) begin
      result_value <= sat_val;
      result_index <= kdiv + 4'd1;
      singular     <= 1'b0;
      last         <= (kdiv == LAST_ENTRY);
    end
  end

endmodule

`default_nettype wire
